[src/cbcmac_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// CBC-MAC package
// AES constants and the byte level functions of one cipher round.
// ---------------------------------------------------------------------------
package cbcmac_pkg;

   localparam int WORD_W   = 64;
   localparam int BLOCK_W  = 128;
   localparam int KEY_W    = 256;
   localparam int KWORD_W  = 32;
   localparam int WIN_N    = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_B   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_C   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LEN = 3'd4;

   localparam logic [1:0] KEY_LEN_128 = 2'd0;
   localparam logic [1:0] KEY_LEN_192 = 2'd1;

   localparam logic [7:0] RCON_INIT = 8'h01;

   localparam logic [0:255][7:0] SBOX = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // One cipher round without the round key; the final round skips the
   // column mixing. Byte 4*c+r sits at bits 8*(4*c+r).
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
      logic [127:0] t;
      logic [127:0] m;
      logic [7:0]   a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[32*c +: 8];
         a1 = t[32*c+8 +: 8];
         a2 = t[32*c+16 +: 8];
         a3 = t[32*c+24 +: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         m[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
         m[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
         m[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         m[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      aes_round = fin ? t : m;
   endfunction

endpackage
`default_nettype wire

[src/aes_cbc_mac_length_prefixed_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// Length-prefixed AES CBC-MAC
// Packs 64-bit beats into blocks, chains them through AES and returns the MAC.
// ---------------------------------------------------------------------------
// The block takes one beat at a time. A start beat carries the byte length
// and a data beat eight message bytes; every second beat, and every last
// beat, closes a 16-byte block, which runs through one shared AES round unit
// at one round per cycle while the key schedule is generated alongside, four
// words per cycle. A beat that closes a block holds off the next beat until
// the last round for the 128, 192 or 256 bit key is done, and a final beat
// then waits in the MAC state until the output register is free. The MAC is
// held in an output register, so the next beat is taken while it waits. Key
// registers may be written only while the block is idle.
module aes_cbc_mac_length_prefixed_top
   import cbcmac_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [WORD_W-1:0]    req_word,
   input  wire logic [3:0]           req_valid_bytes,
   input  wire logic                 req_last_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [WORD_W-1:0]         rsp_mac_first,
   output logic [WORD_W-1:0]         rsp_mac_second,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_MAC  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [KEY_W-1:0]       key_ff;
   logic [1:0]             klen_ff;
   logic [BLOCK_W-1:0]     chain_ff, chain_in;
   logic [WORD_W-1:0]      pend_ff, pend_in;
   logic                   held_ff, held_in;
   logic [BLOCK_W-1:0]     aes_ff, aes_in;
   logic [3:0]             rnd_ff, rnd_in;
   logic                   last_ff, last_in;
   logic [WIN_N-1:0][KWORD_W-1:0] win_ff;
   logic [2:0]             idx_ff;
   logic [7:0]             rc_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]      mac_first_ff, mac_first_in;
   logic [WORD_W-1:0]      mac_second_ff, mac_second_in;

   logic [3:0]             nk;
   logic [3:0]             nr;
   logic [2:0]             base;
   logic [WIN_N-1:0][KWORD_W-1:0] win_key, win_src, win_nxt;
   logic [11:0][KWORD_W-1:0] ext;
   logic [2:0]             idx_src, idx_nxt;
   logic [7:0]             rc_src, rc_nxt;
   logic [BLOCK_W-1:0]     rk;
   logic [BLOCK_W-1:0]     round_out;
   logic                   accept;
   logic                   out_free;
   logic [WORD_W-1:0]      data_w;
   logic [3:0]             nb;

   always_comb begin
      unique case (klen_ff)
         KEY_LEN_128: nk = 4'd4;
         KEY_LEN_192: nk = 4'd6;
         default:     nk = 4'd8;
      endcase
      nr   = nk + 4'd6;
      base = 3'(4'd8 - nk);
   end

   always_comb begin
      for (int i = 0; i < WIN_N; i++) begin
         win_key[i] = '0;
         if (i >= int'(base)) begin
            win_key[i] = key_ff[KWORD_W*(i-int'(base)) +: KWORD_W];
         end
      end
   end

   assign win_src = (state_ff == ST_IDLE) ? win_key : win_ff;
   assign idx_src = (state_ff == ST_IDLE) ? 3'd0 : idx_ff;
   assign rc_src  = (state_ff == ST_IDLE) ? RCON_INIT : rc_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         rk[KWORD_W*j +: KWORD_W] = win_src[base + 3'(j)];
      end
   end

   always_comb begin
      logic [3:0]          m;
      logic [KWORD_W-1:0]  t;
      logic [7:0]          rcc;
      logic [3:0]          far;
      ext[7:0] = win_src;
      ext[11:8] = '0;
      rcc = rc_src;
      for (int k = 0; k < 4; k++) begin
         m = {1'b0, idx_src} + 4'(k);
         if (m >= nk) begin
            m = m - nk;
         end
         t = ext[7+k];
         if (m == 4'd0) begin
            t = sub_word({t[7:0], t[31:8]}) ^ {24'd0, rcc};
            rcc = xtime(rcc);
         end else if (nk == 4'd8 && m == 4'd4) begin
            t = sub_word(t);
         end
         far = 4'(8 + k) - nk;
         ext[8+k] = ext[far] ^ t;
      end
      win_nxt = ext[11:4];
      rc_nxt  = rcc;
      m = {1'b0, idx_src} + 4'd4;
      if (m >= nk) begin
         m = m - nk;
      end
      idx_nxt = m[2:0];
   end

   assign round_out = aes_round(aes_ff, rnd_ff == nr) ^ rk;

   always_comb begin
      nb = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
      for (int b = 0; b < 8; b++) begin
         data_w[8*b +: 8] = (4'(b) < nb) ? req_word[8*b +: 8] : 8'h00;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      logic [WORD_W-1:0]  blk_lo, blk_hi;
      logic [BLOCK_W-1:0] csel;
      logic               enc;
      state_in      = state_ff;
      chain_in      = chain_ff;
      pend_in       = pend_ff;
      held_in       = held_ff;
      aes_in        = aes_ff;
      rnd_in        = rnd_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mac_first_in  = mac_first_ff;
      mac_second_in = mac_second_ff;
      blk_lo = pend_ff;
      blk_hi = '0;
      csel   = chain_ff;
      enc    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_cmd) begin
                  chain_in = '0;
                  csel     = '0;
                  pend_in  = req_word;
                  held_in  = 1'b1;
                  blk_lo   = req_word;
                  enc      = req_last_word;
               end else if (held_ff) begin
                  blk_hi  = data_w;
                  pend_in = '0;
                  held_in = 1'b0;
                  enc     = 1'b1;
               end else begin
                  pend_in = data_w;
                  held_in = 1'b1;
                  blk_lo  = data_w;
                  enc     = req_last_word;
               end
               if (enc) begin
                  aes_in   = {blk_hi, blk_lo} ^ csel ^ rk;
                  rnd_in   = 4'd1;
                  last_in  = req_last_word;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            aes_in = round_out;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == nr) begin
               chain_in = round_out;
               state_in = last_ff ? ST_MAC : ST_IDLE;
            end
         end
         ST_MAC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               mac_first_in  = chain_ff[WORD_W-1:0];
               mac_second_in = chain_ff[BLOCK_W-1:WORD_W];
               chain_in      = '0;
               pend_in       = '0;
               held_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= '0;
         klen_ff      <= KEY_LEN_128;
         chain_ff     <= '0;
         pend_ff      <= '0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         pend_ff      <= pend_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_KEY_A:   key_ff[63:0]    <= csr_wdata;
               CSR_KEY_B:   key_ff[127:64]  <= csr_wdata;
               CSR_KEY_C:   key_ff[191:128] <= csr_wdata;
               CSR_KEY_D:   key_ff[255:192] <= csr_wdata;
               CSR_KEY_LEN: klen_ff         <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      aes_ff        <= aes_in;
      rnd_ff        <= rnd_in;
      last_ff       <= last_in;
      mac_first_ff  <= mac_first_in;
      mac_second_ff <= mac_second_in;
      if (accept || state_ff == ST_RUN) begin
         win_ff <= win_nxt;
         idx_ff <= idx_nxt;
         rc_ff  <= rc_nxt;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mac_first  = mac_first_ff;
   assign rsp_mac_second = mac_second_ff;

endmodule
`default_nettype wire

[tb/sv/aes_cbc_mac_length_prefixed_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Length-prefixed AES CBC-MAC testbench
// Drives directed and random messages under several keys and key sizes,
// predicts every MAC with an independent AES model and compares each
// returned MAC beat against the oldest prediction.
// ---------------------------------------------------------------------------
module aes_cbc_mac_length_prefixed_top_tb
   import cbcmac_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int PHASE_BEATS    = 230;
   localparam int DIRECTED_N     = 22;

   typedef struct packed {
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] second;
   } mac_type;

   typedef struct packed {
      logic              cmd;
      logic [WORD_W-1:0] word;
      logic [3:0]        vb;
      logic              last;
   } beat_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_cmd;
   logic [WORD_W-1:0]    req_word;
   logic [3:0]           req_valid_bytes;
   logic                 req_last_word;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [WORD_W-1:0]    rsp_mac_first;
   logic [WORD_W-1:0]    rsp_mac_second;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   aes_cbc_mac_length_prefixed_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_word        (req_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last_word   (req_last_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mac_first   (rsp_mac_first),
      .rsp_mac_second  (rsp_mac_second),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Shadow of the key registers and the chaining state.
   logic [WORD_W-1:0]  key_reg [4];
   logic [1:0]         key_len;
   logic [BLOCK_W-1:0] chain;
   logic [WORD_W-1:0]  held_word;
   logic               held;
   logic [BLOCK_W-1:0] rkeys [15];
   int                 rounds;

   mac_type expected_macs [$];
   int      errors;
   int      quiet_cycles;
   int      tx_idle;
   int      rx_idle;
   bit      hold_rsp;

   function automatic logic [7:0] gmul2(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   task automatic build_schedule();
      logic [31:0]      w [60];
      logic [KEY_W-1:0] k;
      logic [31:0]      t;
      logic [7:0]       rc;
      logic [7:0]       f;
      int               nk;
      int               total;
      k = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
      nk = (key_len == 2'd0) ? 4 : (key_len == 2'd1) ? 6 : 8;
      rounds = nk + 6;
      total = 4 * (rounds + 1);
      rc = 8'h01;
      for (int i = 0; i < nk; i++) w[i] = k[32*i +: 32];
      for (int i = nk; i < total; i++) begin
         t = w[i-1];
         if (i % nk == 0) begin
            f = t[7:0];
            t = {SBOX[f], SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]] ^ rc};
            rc = gmul2(rc);
         end else if (nk > 6 && i % nk == 4) begin
            t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
         end
         w[i] = w[i-nk] ^ t;
      end
      for (int r = 0; r < 15; r++) rkeys[r] = '0;
      for (int i = 0; i < total; i++) rkeys[i >> 2][32*(i & 3) +: 32] = w[i];
   endtask

   function automatic logic [BLOCK_W-1:0] encipher(input logic [BLOCK_W-1:0] s_in);
      logic [BLOCK_W-1:0] s;
      logic [BLOCK_W-1:0] t;
      logic [7:0]         a0, a1, a2, a3, al;
      s = s_in ^ rkeys[0];
      for (int r = 1; r <= rounds; r++) begin
         for (int i = 0; i < 16; i++) s[8*i +: 8] = SBOX[s[8*i +: 8]];
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
               t[8*(4*c+i) +: 8] = s[8*(4*((c+i)%4)+i) +: 8];
         if (r != rounds) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[32*c +: 8];
               a1 = t[32*c+8 +: 8];
               a2 = t[32*c+16 +: 8];
               a3 = t[32*c+24 +: 8];
               al = a0 ^ a1 ^ a2 ^ a3;
               t[32*c +: 8]    = a0 ^ al ^ gmul2(a0 ^ a1);
               t[32*c+8 +: 8]  = a1 ^ al ^ gmul2(a1 ^ a2);
               t[32*c+16 +: 8] = a2 ^ al ^ gmul2(a2 ^ a3);
               t[32*c+24 +: 8] = a3 ^ al ^ gmul2(a3 ^ a0);
            end
         end
         s = t ^ rkeys[r];
      end
      return s;
   endfunction

   task automatic predict_mac(input beat_type b);
      logic [WORD_W-1:0] w;
      int                n;
      w = b.word;
      if (!b.cmd) begin
         chain = '0;
         held_word = w;
         held = 1'b1;
      end else begin
         n = (b.vb > 4'd8) ? 8 : int'(b.vb);
         if (n < 8) w = w & ((64'd1 << (8 * n)) - 64'd1);
         if (held) begin
            chain = encipher(chain ^ {w, held_word});
            held_word = '0;
            held = 1'b0;
         end else begin
            held_word = w;
            held = 1'b1;
         end
      end
      if (b.last) begin
         if (held) chain = encipher(chain ^ {64'd0, held_word});
         expected_macs.push_back('{first: chain[63:0], second: chain[127:64]});
         chain = '0;
         held_word = '0;
         held = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      mac_type  exp_mac;
      beat_type b;
      bit       moved;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         key_len = 2'd0;
         chain = '0;
         held_word = '0;
         held = 1'b0;
         build_schedule();
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_we) begin
            moved = 1'b1;
            case (csr_index)
               CSR_KEY_A:   key_reg[0] = csr_wdata;
               CSR_KEY_B:   key_reg[1] = csr_wdata;
               CSR_KEY_C:   key_reg[2] = csr_wdata;
               CSR_KEY_D:   key_reg[3] = csr_wdata;
               CSR_KEY_LEN: key_len = csr_wdata[1:0];
               default: ;
            endcase
            build_schedule();
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            b = '{cmd: req_cmd, word: req_word, vb: req_valid_bytes, last: req_last_word};
            predict_mac(b);
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (expected_macs.size() == 0) begin
               errors++;
               $display("%0t: unexpected MAC beat %h %h", $time, rsp_mac_first,
                        rsp_mac_second);
            end else begin
               exp_mac = expected_macs.pop_front();
               if (rsp_mac_first !== exp_mac.first) begin
                  errors++;
                  $display("%0t: mac_first expected %h actual %h", $time, exp_mac.first,
                           rsp_mac_first);
               end
               if (rsp_mac_second !== exp_mac.second) begin
                  errors++;
                  $display("%0t: mac_second expected %h actual %h", $time, exp_mac.second,
                           rsp_mac_second);
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("aes_cbc_mac_length_prefixed_top_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle);
         end
      end
   end

   task automatic send_beat(input beat_type b);
      if ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= b.cmd;
      req_word        <= b.word;
      req_valid_bytes <= b.vb;
      req_last_word   <= b.last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_macs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // One message or one stray beat; returns the number of beats sent.
   task automatic send_message(output int sent);
      beat_type    b;
      logic [63:0] len;
      int          nwords;
      int          rem;
      bit          big;
      bit          headless;
      sent = 0;
      if ($urandom_range(99) < 12) begin
         b = '{cmd: 1'($urandom_range(1)), word: {$urandom, $urandom},
               vb: 4'($urandom_range(15)), last: 1'($urandom_range(1))};
         send_beat(b);
         sent = 1;
      end else begin
         big = ($urandom_range(19) == 0);
         headless = ($urandom_range(19) == 0);
         len = big ? {$urandom, $urandom} : 64'($urandom_range(48));
         nwords = big ? $urandom_range(1, 6) : int'((len + 7) / 8);
         if (headless && nwords == 0) nwords = 1;
         if (!headless) begin
            b = '{cmd: 1'b0, word: len, vb: 4'($urandom_range(15)), last: (nwords == 0)};
            send_beat(b);
            sent++;
         end
         for (int i = 0; i < nwords; i++) begin
            rem = int'(len % 8);
            b.cmd  = 1'b1;
            b.word = {$urandom, $urandom};
            b.vb   = 4'd8;
            b.last = (i == nwords - 1);
            if (b.last) b.vb = big ? 4'($urandom_range(1, 8)) : (rem == 0 ? 4'd8 : 4'(rem));
            send_beat(b);
            sent++;
         end
      end
   endtask

   initial begin
      beat_type    directed [DIRECTED_N];
      logic [63:0] ones;
      int          sent;
      int          count;
      ones = '1;
      directed = '{
         '{1'b0, 64'd0,              4'd8,  1'b1},
         '{1'b0, ones,               4'd0,  1'b0},
         '{1'b1, ones,               4'd8,  1'b1},
         '{1'b0, 64'd16,             4'd15, 1'b0},
         '{1'b1, ones,               4'd0,  1'b0},
         '{1'b1, ones,               4'd9,  1'b0},
         '{1'b1, ones,               4'd15, 1'b1},
         '{1'b1, 64'h0123456789abcdef, 4'd8, 1'b0},
         '{1'b1, 64'hfedcba9876543210, 4'd3, 1'b1},
         '{1'b1, ones,               4'd1,  1'b1},
         '{1'b0, 64'd5,              4'd8,  1'b0},
         '{1'b1, ones,               4'd5,  1'b1},
         '{1'b0, 64'd12,             4'd8,  1'b0},
         '{1'b1, 64'h8877665544332211, 4'd8, 1'b0},
         '{1'b1, ones,               4'd4,  1'b1},
         '{1'b0, 64'd8,              4'd8,  1'b0},
         '{1'b1, 64'h5555aaaa5555aaaa, 4'd8, 1'b0},
         '{1'b0, 64'd3,              4'd8,  1'b0},
         '{1'b1, ones,               4'd3,  1'b1},
         '{1'b1, 64'd0,              4'd8,  1'b0},
         '{1'b1, ones,               4'd7,  1'b1},
         '{1'b0, 64'h8000000000000000, 4'd8, 1'b1}
      };
      errors          = 0;
      hold_rsp        = 1'b0;
      tx_idle         = 10;
      rx_idle         = 49;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = 1'b0;
      req_word        = '0;
      req_valid_bytes = '0;
      req_last_word   = 1'b0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_N; i++) send_beat(directed[i]);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               write_reg(CSR_KEY_A, {$urandom, $urandom});
               write_reg(CSR_KEY_B, {$urandom, $urandom});
               write_reg(CSR_KEY_LEN, 64'(KEY_LEN_128));
            end
            1: begin
               write_reg(CSR_KEY_A, ones);
               write_reg(CSR_KEY_B, ones);
               write_reg(CSR_KEY_C, ones);
               write_reg(CSR_KEY_D, ones);
               write_reg(CSR_KEY_LEN, 64'd2);
            end
            2: begin
               write_reg(CSR_KEY_A, {$urandom, $urandom});
               write_reg(CSR_KEY_B, {$urandom, $urandom});
               write_reg(CSR_KEY_C, {$urandom, $urandom});
               write_reg(CSR_KEY_LEN, 64'(KEY_LEN_192));
            end
            3: begin
               write_reg(CSR_KEY_A, 64'd0);
               write_reg(CSR_KEY_B, 64'd0);
               write_reg(CSR_KEY_C, 64'd0);
               write_reg(CSR_KEY_D, 64'd0);
               write_reg(CSR_KEY_LEN, ones);
            end
            4: begin
               write_reg(CSR_KEY_A, {$urandom, $urandom});
               write_reg(CSR_KEY_B, {$urandom, $urandom});
               write_reg(CSR_KEY_C, {$urandom, $urandom});
               write_reg(CSR_KEY_D, {$urandom, $urandom});
               write_reg(CSR_KEY_LEN, 64'd2);
            end
            default: begin
               write_reg(CSR_KEY_A, {$urandom, $urandom});
               write_reg(CSR_KEY_B, {$urandom, $urandom});
               write_reg(CSR_KEY_LEN, 64'(KEY_LEN_128));
            end
         endcase
         tx_idle = (p < 2) ? 10 : (p < 4) ? 49 : 0;
         rx_idle = (p < 2) ? 49 : (p < 4) ? 10 : 0;
         count = 0;
         while (count < PHASE_BEATS) begin
            if (p == 1 && count >= 100 && count < 110) hold_rsp = 1'b1;
            if (p == 3 && count >= 100 && count < 110) begin
               req_valid <= 1'b0;
               while (expected_macs.size() != 0) @(posedge clock);
            end
            send_message(sent);
            count += sent;
         end
      end

      drain();
      if (errors == 0) begin
         $display("aes_cbc_mac_length_prefixed_top_tb: clean");
      end else begin
         $display("aes_cbc_mac_length_prefixed_top_tb: errors");
      end
      $finish;
   end

endmodule
